### rtl/mcle_pkg.sv
// ----------------------------------------------------------------------------
// mcle_pkg
// Shared types and constants for the modem clock line to epoch block.
// ----------------------------------------------------------------------------
package mcle_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic scan;
      logic fin1;
      logic fin2;
      logic fin3;
      logic clear;
   } cmd_type;

   // scan phases; field k (0 to 5) occupies 2+4k .. 5+4k, the zone field 27 .. 29
   localparam logic [4:0] PH_SEARCH = 5'd0;
   localparam logic [4:0] PH_BLANKS = 5'd1;
   localparam logic [4:0] PH_FIRST  = 5'd2;
   localparam logic [4:0] PH_SIGN   = 5'd26;
   localparam logic [4:0] PH_ZONE   = 5'd27;
   localparam logic [4:0] PH_ZONE2  = 5'd29;
   localparam logic [4:0] PH_DONE   = 5'd30;
   localparam logic [4:0] PH_STOP   = 5'd31;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_MARKER = 3'd1;
   localparam logic [2:0] ST_FORMAT    = 3'd2;
   localparam logic [2:0] ST_BAD_SIGN  = 3'd3;
   localparam logic [2:0] ST_YEAR      = 3'd4;
   localparam logic [2:0] ST_RANGE     = 3'd5;
   localparam logic [2:0] ST_ZONE      = 3'd6;

   localparam logic [1:0] REG_MIN_YEAR = 2'd0;
   localparam logic [1:0] REG_MAX_YEAR = 2'd1;
   localparam logic [1:0] REG_MAX_ZONE = 2'd2;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic signed [8:0] ZONE_HW_LIMIT = 9'sd72;
   localparam logic [15:0] DAYS_1999_MAR1 = 16'd10651;

   function automatic logic [7:0] marker_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h2B;
         3'd1:    ch = 8'h43;
         3'd2:    ch = 8'h43;
         3'd3:    ch = 8'h4C;
         3'd4:    ch = 8'h4B;
         default: ch = 8'h3A;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] sep_char(input logic [2:0] k);
      logic [7:0] ch;
      unique case (k)
         3'd0, 3'd1: ch = 8'h2F;
         3'd2:       ch = 8'h2C;
         default:    ch = 8'h3A;
      endcase
      return ch;
   endfunction

   // days from march 1 to the first of the month
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         default: d = 9'd275;
      endcase
      return d;
   endfunction

endpackage

### rtl/mcle_ctrl.sv
// ----------------------------------------------------------------------------
// mcle_ctrl
// Sequencer: byte intake, three conversion steps, result handoff.
// ----------------------------------------------------------------------------
module mcle_ctrl
   import mcle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_end_of_response,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_end_of_response) state_in = ST_FIN1;
         end
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: state_in = ST_FIN3;
         ST_FIN3: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      cmd.scan  = req_ready && req_valid;
      cmd.fin1  = (state_ff == ST_FIN1);
      cmd.fin2  = (state_ff == ST_FIN2);
      cmd.fin3  = (state_ff == ST_FIN3);
      cmd.clear = (state_ff == ST_FIN3);
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides active together");

   a_last_starts_fin: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_response) |=> cmd.fin1)
      else $error("last word did not start conversion");

   a_fin_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.fin1 |=> cmd.fin2 ##1 cmd.fin3 ##1 rsp_valid)
      else $error("conversion steps out of order");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before taken");

endmodule

### rtl/mcle_dp.sv
// ----------------------------------------------------------------------------
// mcle_dp
// Datapath: character scanner, field store, range checks, epoch arithmetic.
// ----------------------------------------------------------------------------
module mcle_dp
   import mcle_pkg::*;
#(
   parameter int MAX_RESPONSE_BYTES = 96
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [7:0]         rx_byte,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_write_data,
   output logic [2:0]         status,
   output logic [31:0]        epoch_utc,
   output logic signed [16:0] tz_offset_seconds,
   output logic [11:0]        calendar_year,
   output logic [3:0]         month_value,
   output logic [4:0]         day_value,
   output logic [4:0]         hour_value,
   output logic [5:0]         minute_value,
   output logic [5:0]         second_value,
   output logic signed [7:0]  zone_quarters
);

   localparam int CW = $clog2(MAX_RESPONSE_BYTES);
   localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_RESPONSE_BYTES - 1);

   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         mprog_ff, mprog_in;
   logic [4:0]         phase_ff, phase_in;
   logic [1:0]         chars_ff, chars_in;
   logic               neg_ff, neg_in;
   logic [6:0]         acc_ff, acc_in;
   logic signed [7:0]  store_ff [7];
   logic signed [7:0]  store_in [7];
   logic [7:0]         zsign_ff, zsign_in;
   logic [2:0]         err_ff, err_in;

   logic [6:0] min_year_ff, max_year_ff, max_zone_ff;

   // conversion registers
   logic [2:0]         stat_ff;
   logic signed [7:0]  zz_ff;
   logic [15:0]        days_ff;
   logic [31:0]        prod_ff;
   logic [16:0]        tod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= 7'd24;
         max_year_ff <= 7'd69;
         max_zone_ff <= 7'd56;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MIN_YEAR: min_year_ff <= csr_write_data;
            REG_MAX_YEAR: max_year_ff <= csr_write_data;
            REG_MAX_ZONE: max_zone_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- scanner ----------------
   logic       is_dig, is_ws, run_field;
   logic [3:0] dig;
   logic [4:0] ph, k5;
   logic [2:0] k;
   logic [1:0] sub;
   logic [4:0] base_k, base_next;

   always_comb begin
      count_in = count_ff;
      mprog_in = mprog_ff;
      phase_in = phase_ff;
      chars_in = chars_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      store_in = store_ff;
      zsign_in = zsign_ff;
      err_in   = err_ff;
      is_dig   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= 8'd9) && (rx_byte <= 8'd13));
      dig      = 4'(rx_byte - CH_ZERO);
      run_field = 1'b0;
      ph       = phase_ff;
      k        = 3'd0;
      sub      = 2'd0;
      k5       = 5'd0;
      base_k   = PH_FIRST;
      base_next = PH_FIRST;

      if (cmd.clear) begin
         count_in = '0;
         mprog_in = '0;
         phase_in = PH_SEARCH;
         chars_in = '0;
         neg_in   = 1'b0;
         acc_in   = '0;
         for (int i = 0; i < 7; i++) store_in[i] = '0;
         zsign_in = '0;
         err_in   = '0;
      end else if (cmd.scan && (count_ff < LAST_COUNT)) begin
         if (rx_byte == 8'd0) begin
            count_in = LAST_COUNT;
         end else begin
            count_in = count_ff + 1'b1;
            if (phase_ff == PH_SEARCH) begin
               if (rx_byte == marker_char(mprog_ff)) begin
                  mprog_in = mprog_ff + 1'b1;
                  if (mprog_ff == 3'd5) phase_in = PH_BLANKS;
               end else begin
                  mprog_in = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
               end
            end else if (phase_ff == PH_BLANKS) begin
               if (rx_byte == CH_SPACE || rx_byte == CH_TAB) begin
                  phase_in = phase_ff;
               end else if (rx_byte == CH_QUOTE) begin
                  phase_in = PH_FIRST;
               end else begin
                  run_field = 1'b1;
                  ph = PH_FIRST;
               end
            end else if (phase_ff < PH_DONE) begin
               run_field = 1'b1;
            end
         end
      end

      if (run_field) begin
         if (ph == PH_SIGN) begin
            zsign_in = rx_byte;
            phase_in = PH_ZONE;
         end else begin
            if (ph >= PH_ZONE) begin
               k   = 3'd6;
               sub = 2'(ph - PH_ZONE);
            end else begin
               k5  = ph - PH_FIRST;
               k   = k5[4:2];
               sub = k5[1:0];
            end
            base_k    = (k == 3'd6) ? PH_ZONE : 5'(5'd2 + {k, 2'b00});
            base_next = 5'(5'd6 + {k, 2'b00});
            unique case (sub)
               2'd3: begin
                  if (k < 3'd5 && rx_byte == sep_char(k)) phase_in = base_next;
                  else begin
                     err_in = ST_FORMAT;
                     phase_in = PH_STOP;
                  end
               end
               2'd0: begin
                  if (is_ws) begin
                     phase_in = ph;
                  end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                     neg_in   = (rx_byte == CH_MINUS);
                     chars_in = 2'd1;
                     phase_in = base_k + 5'd1;
                  end else if (is_dig) begin
                     acc_in   = {3'b000, dig};
                     chars_in = 2'd1;
                     phase_in = base_k + 5'd2;
                  end else begin
                     err_in = ST_FORMAT;
                     phase_in = PH_STOP;
                  end
               end
               default: begin
                  if (sub == 2'd1 && !is_dig) begin
                     err_in = ST_FORMAT;
                     phase_in = PH_STOP;
                  end else begin
                     // field complete
                     if (sub == 2'd1)
                        store_in[k] = neg_ff ? -$signed({4'b0000, dig})
                                             : $signed({4'b0000, dig});
                     else if (is_dig)
                        store_in[k] = $signed({1'b0, 7'(acc_ff * 7'd10 + {3'b000, dig})});
                     else
                        store_in[k] = $signed({1'b0, acc_ff});
                     chars_in = '0;
                     neg_in   = 1'b0;
                     acc_in   = '0;
                     if (k < 3'd5) phase_in = base_k + 5'd3;
                     else if (k == 3'd5) phase_in = PH_SIGN;
                     else phase_in = PH_DONE;
                     // a non-digit ending a one-digit field is the next char
                     if (sub == 2'd2 && !is_dig) begin
                        if (k < 3'd5) begin
                           if (rx_byte == sep_char(k)) phase_in = base_next;
                           else begin
                              err_in = ST_FORMAT;
                              phase_in = PH_STOP;
                           end
                        end else if (k == 3'd5) begin
                           zsign_in = rx_byte;
                           phase_in = PH_ZONE;
                        end
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mprog_ff <= '0;
         phase_ff <= PH_SEARCH;
         chars_ff <= '0;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         for (int i = 0; i < 7; i++) store_ff[i] <= '0;
         zsign_ff <= '0;
         err_ff   <= '0;
      end else begin
         count_ff <= count_in;
         mprog_ff <= mprog_in;
         phase_ff <= phase_in;
         chars_ff <= chars_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         store_ff <= store_in;
         zsign_ff <= zsign_in;
         err_ff   <= err_in;
      end
   end

   // ---------------- checks and day count ----------------
   logic signed [7:0] zraw, zz;
   logic signed [8:0] yy9, zz9, mz9;
   logic              done_ok, le2;
   logic [2:0]        stat_in;
   logic [6:0]        t;
   logic [6:0]        f;
   logic [15:0]       days_in;

   always_comb begin
      zraw    = (phase_ff == PH_ZONE2) ? $signed({1'b0, acc_ff}) : store_ff[6];
      done_ok = (phase_ff == PH_DONE) || (phase_ff == PH_ZONE2);
      zz      = (zsign_ff == CH_MINUS) ? -zraw : zraw;
      yy9     = 9'(store_ff[0]);
      zz9     = 9'(zz);
      mz9     = $signed({2'b00, max_zone_ff});
      priority if (phase_ff == PH_SEARCH) stat_in = ST_NO_MARKER;
      else if (err_ff != 3'd0 || !done_ok) stat_in = ST_FORMAT;
      else if (zsign_ff != CH_MINUS && zsign_ff != CH_PLUS) stat_in = ST_BAD_SIGN;
      else if (yy9 < $signed({2'b00, min_year_ff}) || yy9 > $signed({2'b00, max_year_ff}))
         stat_in = ST_YEAR;
      else if (store_ff[1] < 8'sd1 || store_ff[1] > 8'sd12 ||
               store_ff[2] < 8'sd1 || store_ff[2] > 8'sd31 ||
               store_ff[3] < 8'sd0 || store_ff[3] > 8'sd23 ||
               store_ff[4] < 8'sd0 || store_ff[4] > 8'sd59 ||
               store_ff[5] < 8'sd0 || store_ff[5] > 8'sd59)
         stat_in = ST_RANGE;
      else if (zz9 < -mz9 || zz9 > mz9 || zz9 < -ZONE_HW_LIMIT || zz9 > ZONE_HW_LIMIT)
         stat_in = ST_ZONE;
      else stat_in = ST_OK;

      // years counted from march 1999; f counts the leap days passed since then
      le2     = (store_ff[1] <= 8'sd2);
      t       = 7'(store_ff[0][6:0] + 7'd1 - {6'b0, le2});
      f       = 7'((t + 7'd3) >> 2);
      days_in = 16'(DAYS_1999_MAR1 + 16'(16'(t) * 16'd365) + {9'b0, f}
                + {7'b0, month_offset(store_ff[1][3:0])}
                + {11'b0, store_ff[2][4:0]} - 16'd1);
   end

   always_ff @(posedge clock) begin
      if (cmd.fin1) begin
         stat_ff <= stat_in;
         zz_ff   <= zz;
         days_ff <= days_in;
      end
      if (cmd.fin2) begin
         prod_ff <= {16'b0, days_ff} * 32'd86400;
         tod_ff  <= 17'(store_ff[3][4:0]) * 17'd3600 + 17'(store_ff[4][5:0]) * 17'd60
                    + {11'b0, store_ff[5][5:0]};
      end
   end

   logic signed [16:0] tz_s;
   assign tz_s = 17'(zz_ff * 17'sd900);

   always_ff @(posedge clock) begin
      if (cmd.fin3) begin
         status <= stat_ff;
         if (stat_ff == ST_OK) begin
            epoch_utc         <= prod_ff + {15'b0, tod_ff} - {{15{tz_s[16]}}, tz_s};
            tz_offset_seconds <= tz_s;
            calendar_year     <= 12'd2000 + {5'b0, store_ff[0][6:0]};
            month_value       <= store_ff[1][3:0];
            day_value         <= store_ff[2][4:0];
            hour_value        <= store_ff[3][4:0];
            minute_value      <= store_ff[4][5:0];
            second_value      <= store_ff[5][5:0];
            zone_quarters     <= zz_ff;
         end else begin
            epoch_utc         <= '0;
            tz_offset_seconds <= '0;
            calendar_year     <= '0;
            month_value       <= '0;
            day_value         <= '0;
            hour_value        <= '0;
            minute_value      <= '0;
            second_value      <= '0;
            zone_quarters     <= '0;
         end
      end
   end

endmodule

### rtl/modem_clock_line_to_epoch.sv
// one word per cycle while scanning: every byte offered while scanning is taken in the cycle it is offered
// the byte marked last starts three conversion steps (checks and day count,
// multiply by 86400, zone correction); the result is registered in ST_FIN3 and shown in ST_RESP
// no new byte is taken until the result word is taken
// synchronous reset clears scan state and loads the register defaults 24, 69, 56
// ----------------------------------------------------------------------------
// modem_clock_line_to_epoch
// Scans a modem clock response and gives its time as seconds since 1970.
// ----------------------------------------------------------------------------
module modem_clock_line_to_epoch
   import mcle_pkg::*;
#(
   parameter int MAX_RESPONSE_BYTES = 96
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_end_of_response,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_epoch_utc,
   output logic signed [16:0] rsp_tz_offset_seconds,
   output logic [11:0]        rsp_calendar_year,
   output logic [3:0]         rsp_month_value,
   output logic [4:0]         rsp_day_value,
   output logic [4:0]         rsp_hour_value,
   output logic [5:0]         rsp_minute_value,
   output logic [5:0]         rsp_second_value,
   output logic signed [7:0]  rsp_zone_quarters,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_write_data
);

   cmd_type cmd;

   mcle_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_end_of_response (req_end_of_response),
      .req_ready           (req_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .cmd                 (cmd)
   );

   mcle_dp #(
      .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .rx_byte           (req_rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .status            (rsp_status),
      .epoch_utc         (rsp_epoch_utc),
      .tz_offset_seconds (rsp_tz_offset_seconds),
      .calendar_year     (rsp_calendar_year),
      .month_value       (rsp_month_value),
      .day_value         (rsp_day_value),
      .hour_value        (rsp_hour_value),
      .minute_value      (rsp_minute_value),
      .second_value      (rsp_second_value),
      .zone_quarters     (rsp_zone_quarters)
   );

endmodule
